[rtl/core/market_record_line_parser_defines.svh]
// Assertion macros for the market record line parser.
`ifndef MARKET_RECORD_LINE_PARSER_DEFINES_SVH
`define MARKET_RECORD_LINE_PARSER_DEFINES_SVH

// Check that a property holds on every clock edge outside reset.
`define MRLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a property holds on every clock edge, reset included.
`define MRLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/mrlp_pkg.sv]
`default_nettype none
package mrlp_pkg;

  localparam int CellCount = 10;
  localparam int SymbolBytesMax = 12;
  localparam int TimestampBytesMax = 16;
  localparam int PriceFractionDigits = 4;

  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChDot = 8'h2E;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChQ = 8'h51;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChB = 8'h42;
  localparam logic [7:0] ChS = 8'h53;

  localparam logic [64:0] PriceLimit = 65'h0_8000_0000_0000_0000;
  localparam logic [64:0] QtyLimit = 65'h0_0000_0000_FFFF_FFFF;

  // Number scanner state for the current price or quantity cell.
  typedef struct packed {
    logic        neg;
    logic        digit;
    logic        dot;
    logic        bad;
    logic        ovf;
    logic        rseen;
    logic        rup;
    logic        start;
    logic [2:0]  frac;
    logic [63:0] acc;
  } num_t;

  // Power of ten for small exponents.
  function automatic logic [23:0] pow10(input int n);
    logic [23:0] r;
    r = 24'd1;
    for (int i = 0; i < n; i++) r = r * 24'd10;
    return r;
  endfunction

  // Multiply by ten and add a digit; flag overflow past the limit.
  function automatic num_t acc_push(input num_t n, input logic [3:0] d,
                                    input logic [64:0] limit);
    num_t r;
    logic [67:0] prod;
    r = n;
    prod = ({4'd0, n.acc} << 3) + ({4'd0, n.acc} << 1) + {64'd0, d};
    if (!n.ovf) begin
      if (prod > {3'd0, limit}) r.ovf = 1'b1;
      else r.acc = prod[63:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/market_record_line_parser.sv]
// Market record line parser. Takes one byte of a comma-separated quote or
// trade line per transaction and, on the byte marked last_byte, delivers one
// record: record_valid with timestamp, symbol, prices scaled by 10^4 and
// quantities, or record_valid low with all other fields zero. A new byte is
// accepted every cycle unless a last byte is held; the result is registered
// from the input register into the output register and waits there, so
// throughput is one byte per cycle as long as the consumer takes results; a
// last byte waits in the input register while an earlier result is not
// taken. The digit accumulate and the price rounding set the path.
`default_nettype none
`include "market_record_line_parser_defines.svh"
module market_record_line_parser
  import mrlp_pkg::*;
#(
  parameter int SYMBOL_BYTES = SymbolBytesMax,
  parameter int TIMESTAMP_BYTES = TimestampBytesMax,
  parameter int PRICE_FRACTION_DIGITS = PriceFractionDigits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  line_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             record_valid,
  output logic             record_kind,
  output logic [63:0]      timestamp_high,
  output logic [63:0]      timestamp_low,
  output logic [31:0]      symbol_high,
  output logic [63:0]      symbol_low,
  output logic [63:0]      first_price,
  output logic [31:0]      first_qty,
  output logic [63:0]      second_price,
  output logic [31:0]      second_qty,
  output logic             sell_side
);

  // Input register.
  logic       b_valid;
  logic [7:0] b_ch;
  logic       b_last;
  logic       step;

  assign in_ready = !b_valid || !b_last || !out_valid || out_ready;
  assign step = b_valid && (!b_last || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_ready) begin
      b_valid <= in_valid;
    end
    if (in_ready) begin
      b_ch <= line_byte;
      b_last <= last_byte;
    end
  end

  logic [3:0]   cell_number;
  logic         line_bad;
  logic [9:0]   cell_filled_mask;
  logic [15:0]  kind_chars;
  logic [1:0]   kind_length;
  logic [127:0] stamp_store;
  logic [4:0]   stamp_length;
  logic [95:0]  symbol_store;
  logic [3:0]   symbol_length;
  logic [63:0]  price_a;
  logic [31:0]  qty_a;
  logic [63:0]  price_b;
  logic [31:0]  qty_b;
  logic [7:0]   side_char;
  logic [1:0]   side_length;

  logic is_comma;
  logic is_price;
  logic is_qty;
  logic end_now;
  logic clear_num;
  logic price_ok;
  logic [63:0] price_val;
  logic qty_ok;
  logic [31:0] qty_val;

  assign is_comma = b_ch == ChComma;
  assign is_price = !is_comma && (cell_number == 4'd3 || cell_number == 4'd5 ||
                                  cell_number == 4'd7);
  assign is_qty = !is_comma && (cell_number == 4'd4 || cell_number == 4'd6 ||
                                cell_number == 4'd8);
  assign end_now = is_comma || b_last;
  assign clear_num = step && end_now;

  mrlp_number #(.PRICE_FRACTION_DIGITS(PRICE_FRACTION_DIGITS)) u_num (
    .clk(clk), .rst(rst), .step(step), .clear(clear_num),
    .is_price(is_price), .is_qty(is_qty), .ch(b_ch),
    .price_ok(price_ok), .price_val(price_val),
    .qty_ok(qty_ok), .qty_val(qty_val)
  );

  // Next line state.
  logic [3:0]   cell_number_next;
  logic         line_bad_next;
  logic [9:0]   mask_next;
  logic [15:0]  kind_chars_next;
  logic [1:0]   kind_length_next;
  logic [127:0] stamp_next;
  logic [4:0]   stamp_length_next;
  logic [95:0]  symbol_next;
  logic [3:0]   symbol_length_next;
  logic [63:0]  price_a_next;
  logic [31:0]  qty_a_next;
  logic [63:0]  price_b_next;
  logic [31:0]  qty_b_next;
  logic [7:0]   side_char_next;
  logic [1:0]   side_length_next;

  always_comb begin
    cell_number_next = cell_number;
    line_bad_next = line_bad;
    mask_next = cell_filled_mask;
    kind_chars_next = kind_chars;
    kind_length_next = kind_length;
    stamp_next = stamp_store;
    stamp_length_next = stamp_length;
    symbol_next = symbol_store;
    symbol_length_next = symbol_length;
    price_a_next = price_a;
    qty_a_next = qty_a;
    price_b_next = price_b;
    qty_b_next = qty_b;
    side_char_next = side_char;
    side_length_next = side_length;
    if (!is_comma) begin
      mask_next[cell_number] = 1'b1;
      case (cell_number)
        4'd0: begin
          if (stamp_length >= 5'(TIMESTAMP_BYTES)) begin
            line_bad_next = 1'b1;
          end else begin
            stamp_next[8'(127 - 8 * stamp_length) -: 8] = b_ch;
            stamp_length_next = stamp_length + 1'b1;
          end
        end
        4'd1: begin
          if (kind_length == 2'd0) kind_chars_next = {8'd0, b_ch};
          else if (kind_length == 2'd1) kind_chars_next[15:8] = b_ch;
          if (kind_length < 2'd3) kind_length_next = kind_length + 1'b1;
        end
        4'd2: begin
          if (symbol_length >= 4'(SYMBOL_BYTES)) begin
            line_bad_next = 1'b1;
          end else begin
            symbol_next[7'(95 - 8 * symbol_length) -: 8] = b_ch;
            symbol_length_next = symbol_length + 1'b1;
          end
        end
        4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8: begin
        end
        default: begin
          if (side_length == 2'd0) side_char_next = b_ch;
          if (side_length < 2'd3) side_length_next = side_length + 1'b1;
        end
      endcase
    end
    if (end_now && mask_next[cell_number]) begin
      case (cell_number)
        4'd3, 4'd7: begin
          if (price_ok) price_a_next = price_val;
          else line_bad_next = 1'b1;
        end
        4'd5: begin
          if (price_ok) price_b_next = price_val;
          else line_bad_next = 1'b1;
        end
        4'd4, 4'd8: begin
          if (qty_ok) qty_a_next = qty_val;
          else line_bad_next = 1'b1;
        end
        4'd6: begin
          if (qty_ok) qty_b_next = qty_val;
          else line_bad_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (is_comma) begin
      if (cell_number >= 4'(CellCount - 1)) line_bad_next = 1'b1;
      else cell_number_next = cell_number + 1'b1;
    end
  end

  // Final verdict on the last byte.
  logic ok;
  logic quote;
  logic trade;
  logic side_ok;

  always_comb begin
    quote = kind_length_next == 2'd1 && kind_chars_next == {8'd0, ChQ};
    trade = kind_length_next == 2'd1 && kind_chars_next == {8'd0, ChT};
    side_ok = side_length_next == 2'd1 &&
              (side_char_next == ChB || side_char_next == ChS);
    ok = !line_bad_next && cell_number_next == 4'(CellCount - 1) &&
         mask_next[0] && mask_next[2];
    if (quote) ok = ok && mask_next[6:3] == 4'hF && mask_next[9:7] == 3'd0;
    else if (trade) ok = ok && mask_next[6:3] == 4'h0 && mask_next[9:7] == 3'h7 &&
                         side_ok;
    else ok = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && b_last)) begin
      cell_number <= '0;
      line_bad <= 1'b0;
      cell_filled_mask <= '0;
      kind_chars <= '0;
      kind_length <= '0;
      stamp_store <= '0;
      stamp_length <= '0;
      symbol_store <= '0;
      symbol_length <= '0;
      price_a <= '0;
      qty_a <= '0;
      price_b <= '0;
      qty_b <= '0;
      side_char <= '0;
      side_length <= '0;
    end else if (step) begin
      cell_number <= cell_number_next;
      line_bad <= line_bad_next;
      cell_filled_mask <= mask_next;
      kind_chars <= kind_chars_next;
      kind_length <= kind_length_next;
      stamp_store <= stamp_next;
      stamp_length <= stamp_length_next;
      symbol_store <= symbol_next;
      symbol_length <= symbol_length_next;
      price_a <= price_a_next;
      qty_a <= qty_a_next;
      price_b <= price_b_next;
      qty_b <= qty_b_next;
      side_char <= side_char_next;
      side_length <= side_length_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && b_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (step && b_last) begin
      record_valid <= ok;
      record_kind <= ok && trade;
      timestamp_high <= ok ? stamp_next[127:64] : '0;
      timestamp_low <= ok ? stamp_next[63:0] : '0;
      symbol_high <= ok ? symbol_next[95:64] : '0;
      symbol_low <= ok ? symbol_next[63:0] : '0;
      first_price <= ok ? price_a_next : '0;
      first_qty <= ok ? qty_a_next : '0;
      second_price <= (ok && quote) ? price_b_next : '0;
      second_qty <= (ok && quote) ? qty_b_next : '0;
      sell_side <= ok && trade && side_char_next == ChS;
    end
  end

  `MRLP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
  `MRLP_ASSERT(a_step_room, step && b_last |-> !out_valid || out_ready,
               "result overwritten")
  `MRLP_ASSERT(a_cell_range, cell_number <= 4'(CellCount - 1), "cell count out of range")
  `MRLP_ASSERT(a_valid_zero, out_valid && !record_valid |-> first_price == 64'd0 &&
               first_qty == 32'd0, "invalid record carries data")

endmodule
`default_nettype wire

[rtl/core/mrlp_number.sv]
`default_nettype none
module mrlp_number
  import mrlp_pkg::*;
#(
  parameter int PRICE_FRACTION_DIGITS = PriceFractionDigits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        clear,
  input  wire logic        is_price,
  input  wire logic        is_qty,
  input  wire logic [7:0]  ch,
  output logic             price_ok,
  output logic [63:0]      price_val,
  output logic             qty_ok,
  output logic [31:0]      qty_val
);

  localparam int FracW = 3;
  localparam logic [FracW-1:0] FracMax = FracW'(PRICE_FRACTION_DIGITS);
  localparam logic [23:0] IntScale = pow10(PRICE_FRACTION_DIGITS);

  num_t num;
  num_t num_next;
  logic is_digit;
  logic [3:0] d;
  logic [23:0] frac_scale;
  logic [67:0] int_sum;
  logic [67:0] frac_sum;
  logic [67:0] price_sum;
  logic [64:0] rounded;

  assign is_digit = (ch >= ChZero) && (ch <= ChNine);
  assign d = 4'(ch - ChZero);

  // Keep price digits scaled to the fixed fraction width as they arrive.
  always_comb begin
    frac_scale = '0;
    for (int k = 0; k < 7; k++) begin
      if (k < PRICE_FRACTION_DIGITS && 3'(k) == num.frac) begin
        frac_scale = pow10(PRICE_FRACTION_DIGITS - 1 - k);
      end
    end
  end

  assign int_sum = ({4'd0, num.acc} << 3) + ({4'd0, num.acc} << 1) +
                   {44'd0, 24'(d) * IntScale};
  assign frac_sum = {4'd0, num.acc} + {44'd0, 24'(d) * frac_scale};
  assign price_sum = num.dot ? frac_sum : int_sum;

  always_comb begin
    num_next = num;
    if (is_price) begin
      if (ch == ChMinus || ch == ChPlus) begin
        if (num.start) num_next.bad = 1'b1;
        else if (ch == ChMinus) num_next.neg = 1'b1;
      end else if (ch == ChDot) begin
        if (num.dot) num_next.bad = 1'b1;
        else num_next.dot = 1'b1;
      end else if (is_digit) begin
        num_next.digit = 1'b1;
        if (!num.dot || num.frac < FracMax) begin
          if (!num.ovf) begin
            if (price_sum > {3'd0, PriceLimit}) num_next.ovf = 1'b1;
            else num_next.acc = price_sum[63:0];
          end
          if (num.dot) num_next.frac = num.frac + 1'b1;
        end else if (!num.rseen) begin
          num_next.rseen = 1'b1;
          if (d >= 4'd5) num_next.rup = 1'b1;
        end
      end else begin
        num_next.bad = 1'b1;
      end
      num_next.start = 1'b1;
    end else if (is_qty) begin
      if (is_digit) begin
        num_next.digit = 1'b1;
        num_next = acc_push(num_next, d, QtyLimit);
      end else begin
        num_next.bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      num <= '0;
    end else if (step) begin
      num <= num_next;
    end
  end

  // Finish on the state with the current byte folded in.
  assign rounded = {1'b0, num_next.acc} + {64'd0, num_next.rup};

  always_comb begin
    price_ok = !num_next.bad && num_next.digit && !num_next.ovf;
    if (num_next.rup && {1'b0, num_next.acc} >= PriceLimit) price_ok = 1'b0;
    if (!num_next.neg && rounded >= PriceLimit) price_ok = 1'b0;
    price_val = num_next.neg ? (64'd0 - rounded[63:0]) : rounded[63:0];
    qty_ok = !num_next.bad && !num_next.ovf && num_next.digit;
    qty_val = num_next.acc[31:0];
  end

endmodule
`default_nettype wire

[bench/market_record_line_parser_tb.sv]
`timescale 1ns / 1ps
module market_record_line_parser_tb;
  import mrlp_pkg::*;

  typedef logic [7:0] u8;

  typedef struct {
    logic        ok;
    logic        kind;
    logic [63:0] ts_hi;
    logic [63:0] ts_lo;
    logic [31:0] sym_hi;
    logic [63:0] sym_lo;
    logic [63:0] px1;
    logic [31:0] qty1;
    logic [63:0] px2;
    logic [31:0] qty2;
    logic        side;
  } record_t;

  class record_scoreboard;
    record_t     pending[$];
    int          errors;
    int unsigned col;
    logic        bad;
    logic [9:0]  mask;
    logic [15:0] kchars;
    int unsigned klen;
    logic [63:0] stamp[2];
    int unsigned slen;
    u8           sym[12];
    int unsigned symlen;
    logic [63:0] acc;
    logic        neg, digit, dot, nbad, ovf, rseen, rup, start;
    int unsigned frac;
    logic [63:0] pa, pb;
    logic [31:0] qa, qb;
    u8           side;
    int unsigned sidelen;

    function void clear_line();
      col = 0; bad = 0; mask = 0; kchars = 0; klen = 0;
      stamp[0] = 0; stamp[1] = 0; slen = 0;
      foreach (sym[i]) sym[i] = 0;
      symlen = 0;
      clear_number();
      pa = 0; pb = 0; qa = 0; qb = 0; side = 0; sidelen = 0;
    endfunction

    function void clear_number();
      acc = 0; frac = 0;
      {neg, digit, dot, nbad, ovf, rseen, rup, start} = 0;
    endfunction

    function void push_digit(int unsigned d, logic [64:0] limit);
      if (ovf) return;
      if ({1'b0, acc} > (limit - d) / 10) ovf = 1;
      else acc = acc * 10 + d;
    endfunction

    function logic finish_price(output logic [63:0] v);
      v = 0;
      if (nbad || !digit) return 0;
      for (int k = frac; k < PriceFractionDigits; k++) push_digit(0, PriceLimit);
      if (rup && !ovf) begin
        if ({1'b0, acc} >= PriceLimit) ovf = 1;
        else acc = acc + 1;
      end
      if (ovf) return 0;
      if (!neg && {1'b0, acc} >= PriceLimit) return 0;
      v = neg ? -acc : acc;
      return 1;
    endfunction

    function logic finish_qty(output logic [31:0] v);
      v = 0;
      if (nbad || ovf || !digit) return 0;
      v = acc[31:0];
      return 1;
    endfunction

    function void close_cell();
      logic ok;
      logic [63:0] p;
      logic [31:0] q;
      ok = 1;
      if (mask[col]) begin
        if (col == 3 || col == 7) begin
          ok = finish_price(p);
          if (ok) pa = p;
        end else if (col == 5) begin
          ok = finish_price(p);
          if (ok) pb = p;
        end else if (col == 4 || col == 8) begin
          ok = finish_qty(q);
          if (ok) qa = q;
        end else if (col == 6) begin
          ok = finish_qty(q);
          if (ok) qb = q;
        end
        if (!ok) bad = 1;
      end
      clear_number();
    endfunction

    function void take(u8 c);
      mask[col] = 1;
      case (col)
        0: begin
          if (slen >= TimestampBytesMax) bad = 1;
          else begin
            stamp[slen / 8][8 * (7 - slen % 8) +: 8] = c;
            slen++;
          end
        end
        1: begin
          if (klen == 0) kchars = {8'd0, c};
          else if (klen == 1) kchars[15:8] = c;
          if (klen < 3) klen++;
        end
        2: begin
          if (symlen >= SymbolBytesMax) bad = 1;
          else begin
            sym[symlen] = c;
            symlen++;
          end
        end
        3, 5, 7: begin
          if (c == ChMinus || c == ChPlus) begin
            if (start) nbad = 1;
            else if (c == ChMinus) neg = 1;
          end else if (c == ChDot) begin
            if (dot) nbad = 1;
            else dot = 1;
          end else if (c >= ChZero && c <= ChNine) begin
            digit = 1;
            if (!dot) push_digit(c - ChZero, PriceLimit);
            else if (frac < PriceFractionDigits) begin
              push_digit(c - ChZero, PriceLimit);
              frac++;
            end else if (!rseen) begin
              rseen = 1;
              if (c - ChZero >= 5) rup = 1;
            end
          end else nbad = 1;
          start = 1;
        end
        4, 6, 8: begin
          if (c >= ChZero && c <= ChNine) begin
            digit = 1;
            push_digit(c - ChZero, QtyLimit);
          end else nbad = 1;
        end
        default: begin
          if (sidelen == 0) side = c;
          if (sidelen < 3) sidelen++;
        end
      endcase
    endfunction

    function void note(u8 c, logic last);
      record_t r;
      logic ok, quote, trade, side_ok;
      if (c == ChComma) begin
        close_cell();
        if (col >= CellCount - 1) bad = 1;
        else col++;
      end else take(c);
      if (!last) return;
      close_cell();
      r = '{default: '0};
      ok = !bad && col == CellCount - 1 && mask[0] && mask[2];
      quote = klen == 1 && kchars == {8'd0, ChQ};
      trade = klen == 1 && kchars == {8'd0, ChT};
      side_ok = sidelen == 1 && (side == ChB || side == ChS);
      if (quote) ok = ok && mask[6:3] == 4'hF && mask[9:7] == 0;
      else if (trade) ok = ok && mask[6:3] == 0 && mask[9:7] == 3'h7 && side_ok;
      else ok = 0;
      if (ok) begin
        r.ok = 1;
        r.kind = trade;
        r.ts_hi = stamp[0];
        r.ts_lo = stamp[1];
        r.sym_hi = {sym[0], sym[1], sym[2], sym[3]};
        r.sym_lo = {sym[4], sym[5], sym[6], sym[7], sym[8], sym[9], sym[10], sym[11]};
        r.px1 = pa;
        r.qty1 = qa;
        if (quote) begin
          r.px2 = pb;
          r.qty2 = qb;
        end else r.side = side == ChS;
      end
      pending.insert(pending.size(), r);
      clear_line();
    endfunction

    function void check(record_t a);
      record_t e;
      if (pending.size() == 0) begin
        $display("%0t: record with no line pending", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.ok !== e.ok || a.kind !== e.kind || a.ts_hi !== e.ts_hi ||
          a.ts_lo !== e.ts_lo || a.sym_hi !== e.sym_hi || a.sym_lo !== e.sym_lo ||
          a.px1 !== e.px1 || a.qty1 !== e.qty1 || a.px2 !== e.px2 ||
          a.qty2 !== e.qty2 || a.side !== e.side) begin
        $display("%0t: mismatch expected ok=%b kind=%b ts=%h_%h sym=%h_%h p1=%0d q1=%0d p2=%0d q2=%0d side=%b",
                 $time, e.ok, e.kind, e.ts_hi, e.ts_lo, e.sym_hi, e.sym_lo,
                 $signed(e.px1), e.qty1, $signed(e.px2), e.qty2, e.side);
        $display("%0t: mismatch actual   ok=%b kind=%b ts=%h_%h sym=%h_%h p1=%0d q1=%0d p2=%0d q2=%0d side=%b",
                 $time, a.ok, a.kind, a.ts_hi, a.ts_lo, a.sym_hi, a.sym_lo,
                 $signed(a.px1), a.qty1, $signed(a.px2), a.qty2, a.side);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  line_byte = 0;
  logic        last_byte = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        record_valid, record_kind, sell_side;
  logic [63:0] timestamp_high, timestamp_low, symbol_low, first_price, second_price;
  logic [31:0] symbol_high, first_qty, second_qty;

  record_scoreboard sb = new();
  int  phase = 0;
  logic want_hold = 0;
  logic held = 0;
  int  hold_cnt = 0;

  market_record_line_parser i_dut (.*);

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    record_t r;
    if (!rst && out_valid && out_ready) begin
      r.ok = record_valid; r.kind = record_kind;
      r.ts_hi = timestamp_high; r.ts_lo = timestamp_low;
      r.sym_hi = symbol_high; r.sym_lo = symbol_low;
      r.px1 = first_price; r.qty1 = first_qty;
      r.px2 = second_price; r.qty2 = second_qty; r.side = sell_side;
      sb.check(r);
    end
  end

  always @(negedge clk) begin
    if (want_hold && !held) begin
      held = 1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 0;
    end else if (phase == 0) out_ready <= $urandom_range(99) >= 82;
    else if (phase == 1) out_ready <= $urandom_range(99) >= 33;
    else out_ready <= 1;
  end

  task automatic send_line(u8 q[$]);
    int gap;
    gap = phase == 0 ? 33 : phase == 1 ? 82 : 0;
    foreach (q[i]) begin
      while ($urandom_range(99) < gap) begin
        in_valid <= 0;
        @(negedge clk);
      end
      in_valid <= 1;
      line_byte <= q[i];
      last_byte <= i == q.size() - 1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sb.note(q[i], i == q.size() - 1);
      @(negedge clk);
    end
  endtask

  task automatic send_text(string s);
    u8 q[$];
    for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
    send_line(q);
  endtask

  function automatic void add_digits(ref u8 q[$], input int n);
    for (int i = 0; i < n; i++) q.insert(q.size(), u8'(ChZero + $urandom_range(9)));
  endfunction

  function automatic void add_price(ref u8 q[$]);
    int k;
    k = $urandom_range(9);
    if (k == 0) q.insert(q.size(), ChMinus);
    else if (k == 1) q.insert(q.size(), ChPlus);
    add_digits(q, $urandom_range(7) == 0 ? $urandom_range(16) : $urandom_range(1, 5));
    if ($urandom_range(2) != 0) begin
      q.insert(q.size(), ChDot);
      add_digits(q, $urandom_range(7));
    end
  endfunction

  function automatic void add_field(ref u8 q[$], input int lo, input int hi);
    u8 c;
    repeat ($urandom_range(lo, hi)) begin
      c = $urandom_range(3) == 0 ? u8'($urandom_range(255)) : u8'($urandom_range(33, 126));
      if (c == ChComma) c = ChZero;
      q.insert(q.size(), c);
    end
  endfunction

  function automatic void make_line(ref u8 q[$]);
    logic trade;
    int p;
    trade = 1'($urandom_range(1));
    add_field(q, 1, $urandom_range(9) == 0 ? 18 : 16);
    q.insert(q.size(), ChComma);
    q.insert(q.size(), trade ? ChT : ChQ);
    q.insert(q.size(), ChComma);
    add_field(q, 1, $urandom_range(9) == 0 ? 14 : 12);
    q.insert(q.size(), ChComma);
    if (!trade) begin
      add_price(q); q.insert(q.size(), ChComma);
      add_digits(q, $urandom_range(1, 10)); q.insert(q.size(), ChComma);
      add_price(q); q.insert(q.size(), ChComma);
      add_digits(q, $urandom_range(1, 10)); q.insert(q.size(), ChComma);
      q.insert(q.size(), ChComma); q.insert(q.size(), ChComma);
    end else begin
      repeat (4) q.insert(q.size(), ChComma);
      add_price(q); q.insert(q.size(), ChComma);
      add_digits(q, $urandom_range(1, 10)); q.insert(q.size(), ChComma);
      q.insert(q.size(), $urandom_range(1) ? ChB : ChS);
    end
    if ($urandom_range(6) == 0) begin
      p = $urandom_range(q.size() - 1);
      if ($urandom_range(1)) q.delete(p);
      else q.insert(p, u8'($urandom_range(255)));
      if (q.size() == 0) q.insert(q.size(), ChComma);
    end
  endfunction

  initial begin
    u8 q[$];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_text("1700000000123,Q,AAPL,101.25,100,-0.5,200,,,");
    send_text("1,T,X,,,,,+3.14159,7,S");
    send_text("1,T,X,,,,,0.00005,4294967295,B");
    send_text("1,T,X,,,,,-0.00005,0,B");
    send_text("1,T,X,,,,,922337203685477.5807,1,B");
    send_text("1,T,X,,,,,922337203685477.58075,1,B");
    send_text("1,T,X,,,,,-922337203685477.5808,1,S");
    send_text("1,T,X,,,,,-922337203685477.58085,1,S");
    send_text("1,T,X,,,,,99999999999999999999,1,S");
    send_text("1,T,X,,,,,1,4294967296,S");
    send_text("1,T,X,,,,,1,+5,S");
    send_text("1,T,X,,,,,1 ,5,S");
    send_text("1,T,X,,,,,1e5,5,S");
    send_text("1,T,X,,,,,1.2.3,5,S");
    send_text("1,T,X,,,,,--1,5,S");
    send_text("1,T,X,,,,,-,5,S");
    send_text("1,T,X,,,,,.,5,S");
    send_text("1,T,X,,,,,1,5,BB");
    send_text("1,T,X,,,,,1,5,S,");
    send_text("1,T,X,,,,,1,5");
    send_text("0123456789ABCDEF,Q,ABCDEFGHIJKL,1,2,3,4,,,");
    send_text("0123456789ABCDEFG,Q,ABCD,1,2,3,4,,,");
    send_text("1,Q,ABCDEFGHIJKLM,1,2,3,4,,,");
    send_text("1,QQ,A,1,2,3,4,,,");
    q = '{8'h31, ChComma, ChQ, ChComma, 8'h00, 8'hFF, ChComma, ChZero, ChComma,
          ChZero, ChComma, ChZero, ChComma, ChZero, ChComma, ChComma, ChComma};
    send_line(q);
    send_text(",");
    for (int n = 0; n < 10; n++) begin
      if (n == 3) begin
        in_valid <= 0;
        wait (sb.pending.size() == 0);
        @(negedge clk);
        phase = 1;
      end
      if (n == 6) begin
        in_valid <= 0;
        wait (sb.pending.size() == 0);
        @(negedge clk);
        phase = 2;
        want_hold = 1;
      end
      q.delete();
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 40)) q.insert(q.size(), u8'($urandom_range(255)));
      end else make_line(q);
      send_line(q);
    end
    in_valid <= 0;
    wait (sb.pending.size() == 0);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
